/* hw/rtl/mi3_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_pkg
// types and constants shared by the 3x3 matrix inverse pipeline
// ----------------------------------------------------------------------------
package mi3_pkg;

	localparam int ELEM_W  = 32;              // q16.16 element
	localparam int PROD_W  = 2 * ELEM_W;      // exact 2x2 product
	localparam int COF_W   = PROD_W + 1;      // exact cofactor
	localparam int LO_W    = COF_W - ELEM_W;  // low slice of a cofactor for det partials
	localparam int DET_W   = 98;              // exact determinant with headroom
	localparam int MAG_W   = 96;              // numerator and divisor magnitude
	localparam int QUO_W   = ELEM_W + 2;      // quotient bits kept, checked against the saturation limit
	localparam int CMP_W   = MAG_W + QUO_W;   // divisor shifted by the top quotient bit
	localparam int N_ELEM  = 9;

	// operand indices of each signed cofactor: x*w - y*z, row-major element order
	localparam int COF_IDX [N_ELEM][4] = '{
		'{4, 8, 7, 5}, '{1, 8, 7, 2}, '{1, 5, 4, 2},
		'{3, 8, 6, 5}, '{0, 8, 6, 2}, '{0, 5, 3, 2},
		'{3, 7, 6, 4}, '{0, 7, 6, 1}, '{0, 4, 3, 1}
	};
	// cofactors that take a minus sign in the adjugate
	localparam logic [N_ELEM-1:0] COF_NEG = 9'b010_101_010;

	typedef struct packed {
		logic signed [ELEM_W-1:0] a00;
		logic signed [ELEM_W-1:0] a01;
		logic signed [ELEM_W-1:0] a02;
		logic signed [ELEM_W-1:0] a10;
		logic signed [ELEM_W-1:0] a11;
		logic signed [ELEM_W-1:0] a12;
		logic signed [ELEM_W-1:0] a20;
		logic signed [ELEM_W-1:0] a21;
		logic signed [ELEM_W-1:0] a22;
	} in_t;

	typedef struct packed {
		logic signed [ELEM_W-1:0] inv00;
		logic signed [ELEM_W-1:0] inv01;
		logic signed [ELEM_W-1:0] inv02;
		logic signed [ELEM_W-1:0] inv10;
		logic signed [ELEM_W-1:0] inv11;
		logic signed [ELEM_W-1:0] inv12;
		logic signed [ELEM_W-1:0] inv20;
		logic signed [ELEM_W-1:0] inv21;
		logic signed [ELEM_W-1:0] inv22;
		logic                     singular;
		logic                     overflow;
	} out_t;

	// state of one divider step, all nine lanes share the divisor
	typedef struct packed {
		logic [N_ELEM-1:0][MAG_W-1:0] rem;
		logic [N_ELEM-1:0][QUO_W-1:0] quo;
		logic [MAG_W-1:0]             dmag;
		logic [N_ELEM-1:0]            neg;
		logic                         singular;
	} div_t;

endpackage

/* hw/rtl/matrix3x3_inverse.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// pipelined adjugate inverse of a signed q16.16 3x3 matrix
// ----------------------------------------------------------------------------
// usage
//   input channel mat_valid / mat_stall / mat carries one matrix per item,
//   output channel inv_valid / inv_stall / inv one inverse per item
//   an item is taken on a clock edge with valid high and stall low
// pipeline and throughput
//   an accepted matrix passes through six stages of products, cofactors,
//   determinant and magnitudes, the 34 step restoring divider (one quotient
//   bit per stage, nine lanes abreast) and the output register to inv_valid;
//   one item per cycle sustained when nothing stalls
// reset
//   arst_n clears every stage valid bit; the pipeline comes up empty
// stall
//   each stage holds while its successor is full and held; bubbles close
//   up, so items keep entering until every stage holds an item
//   the last stage is the output register and holds inv steady while
//   inv_valid and inv_stall are both high
// singular matrices give all-zero elements with singular set
// ----------------------------------------------------------------------------
module matrix3x3_inverse (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          mat_valid,
	output logic          mat_stall,
	input  mi3_pkg::in_t  mat,
	output logic          inv_valid,
	input  logic          inv_stall,
	output mi3_pkg::out_t inv
);
	import mi3_pkg::*;

	localparam int N_DIV   = QUO_W;          // one stage per quotient bit
	localparam int ST_DIV0 = 7;              // first divider stage
	localparam int N_STG   = ST_DIV0 + N_DIV; // output register stage number

	// ---------------------------------------------------------------- flow control
	logic [N_STG:1]   vld;
	logic [N_STG+1:1] rdy;

	assign rdy[N_STG+1] = !inv_stall;

	genvar gk;
	generate
		for (gk = 1; gk <= N_STG; gk++) begin : g_rdy
			// a stage takes new data when empty or when its item moves on
			assign rdy[gk] = !vld[gk] || rdy[gk+1];
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (rdy[1]) begin
				vld[1] <= mat_valid;
			end
			for (int k = 2; k <= N_STG; k++) begin
				if (rdy[k]) begin
					vld[k] <= vld[k-1];
				end
			end
		end
	end

	assign mat_stall = !rdy[1];
	assign inv_valid = vld[N_STG];

	// ---------------------------------------------------------------- stage 1: products
	logic signed [ELEM_W-1:0] a [N_ELEM];

	assign a[0] = mat.a00;
	assign a[1] = mat.a01;
	assign a[2] = mat.a02;
	assign a[3] = mat.a10;
	assign a[4] = mat.a11;
	assign a[5] = mat.a12;
	assign a[6] = mat.a20;
	assign a[7] = mat.a21;
	assign a[8] = mat.a22;

	logic signed [PROD_W-1:0] pxw_s1 [N_ELEM];
	logic signed [PROD_W-1:0] pyz_s1 [N_ELEM];
	logic signed [ELEM_W-1:0] row0_s1 [3];

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			for (int k = 0; k < N_ELEM; k++) begin
				pxw_s1[k] <= a[COF_IDX[k][0]] * a[COF_IDX[k][1]];
				pyz_s1[k] <= a[COF_IDX[k][2]] * a[COF_IDX[k][3]];
			end
			for (int j = 0; j < 3; j++) begin
				row0_s1[j] <= a[j];
			end
		end
	end

	// ---------------------------------------------------------------- stage 2: adjugate
	logic signed [COF_W-1:0]  adj_s2 [N_ELEM];
	logic signed [ELEM_W-1:0] row0_s2 [3];

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			for (int k = 0; k < N_ELEM; k++) begin
				if (COF_NEG[k]) begin
					adj_s2[k] <= COF_W'(pyz_s1[k]) - COF_W'(pxw_s1[k]);
				end else begin
					adj_s2[k] <= COF_W'(pxw_s1[k]) - COF_W'(pyz_s1[k]);
				end
			end
			row0_s2 <= row0_s1;
		end
	end

	// ---------------------------------------------------------------- stage 3: det partials
	// first row times its adjugate column, cut into a low and a high slice
	logic signed [ELEM_W+LO_W:0]     plo_s3 [3];
	logic signed [2*ELEM_W-1:0]      phi_s3 [3];
	logic signed [COF_W-1:0]         adj_s3 [N_ELEM];

	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			for (int j = 0; j < 3; j++) begin
				plo_s3[j] <= row0_s2[j] * $signed({1'b0, adj_s2[3*j][LO_W-1:0]});
				phi_s3[j] <= row0_s2[j] * $signed(adj_s2[3*j][COF_W-1:LO_W]);
			end
			adj_s3 <= adj_s2;
		end
	end

	// ---------------------------------------------------------------- stage 4: det terms
	logic signed [DET_W-1:0] term_s4 [3];
	logic signed [COF_W-1:0] adj_s4 [N_ELEM];

	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			for (int j = 0; j < 3; j++) begin
				term_s4[j] <= DET_W'($signed({phi_s3[j], {LO_W{1'b0}}}))
				              + DET_W'(plo_s3[j]);
			end
			adj_s4 <= adj_s3;
		end
	end

	// ---------------------------------------------------------------- stage 5: determinant
	logic signed [DET_W-1:0] det_s5;
	logic signed [COF_W-1:0] adj_s5 [N_ELEM];

	always_ff @(posedge clk) begin
		if (rdy[5]) begin
			det_s5 <= term_s4[0] + term_s4[1] + term_s4[2];
			adj_s5 <= adj_s4;
		end
	end

	// ---------------------------------------------------------------- stage 6: magnitudes
	logic [DET_W-1:0] det_abs;
	div_t             div_s6;

	assign det_abs = det_s5[DET_W-1] ? DET_W'(-det_s5) : DET_W'(det_s5);

	always_ff @(posedge clk) begin
		if (rdy[6]) begin
			for (int k = 0; k < N_ELEM; k++) begin
				logic [COF_W-1:0] cmag;
				cmag = adj_s5[k][COF_W-1] ? COF_W'(-adj_s5[k]) : COF_W'(adj_s5[k]);
				div_s6.rem[k] <= {cmag[PROD_W-1:0], {ELEM_W{1'b0}}};
				div_s6.quo[k] <= '0;
				div_s6.neg[k] <= adj_s5[k][COF_W-1] ^ det_s5[DET_W-1];
			end
			div_s6.dmag     <= det_abs[MAG_W-1:0];
			div_s6.singular <= (det_s5 == '0);
		end
	end

	// ---------------------------------------------------------------- divider stages
	// restoring division, one quotient bit per stage from the top
	div_t div_s [1:N_DIV];

	genvar gd;
	generate
		for (gd = 0; gd < N_DIV; gd++) begin : g_div
			localparam int BIT = N_DIV - 1 - gd;
			div_t             cur;
			logic [CMP_W-1:0] dsh;
			div_t             nxt;

			if (gd == 0) begin : g_first
				assign cur = div_s6;
			end else begin : g_next
				assign cur = div_s[gd];
			end

			assign dsh = {{QUO_W{1'b0}}, cur.dmag} << BIT;

			always_comb begin
				nxt = cur;
				for (int k = 0; k < N_ELEM; k++) begin
					logic ge;
					ge = ({{QUO_W{1'b0}}, cur.rem[k]} >= dsh);
					nxt.quo[k] = {cur.quo[k][QUO_W-2:0], ge};
					if (ge) begin
						nxt.rem[k] = cur.rem[k] - dsh[MAG_W-1:0];
					end
				end
			end

			always_ff @(posedge clk) begin
				if (rdy[ST_DIV0+gd]) begin
					div_s[gd+1] <= nxt;
				end
			end
		end
	endgenerate

	// ---------------------------------------------------------------- output register
	logic [N_ELEM-1:0][ELEM_W-1:0] elem_d;
	logic [N_ELEM-1:0]             sat_d;
	out_t                          res_d;
	out_t                          inv_s41;

	always_comb begin
		for (int k = 0; k < N_ELEM; k++) begin
			logic [QUO_W-1:0] lim;
			logic [QUO_W-1:0] mag;
			lim = div_s[N_DIV].neg[k] ? QUO_W'(34'h0_8000_0000)
			                          : QUO_W'(34'h0_7FFF_FFFF);
			sat_d[k] = (div_s[N_DIV].quo[k] > lim);
			mag = sat_d[k] ? lim : div_s[N_DIV].quo[k];
			elem_d[k] = div_s[N_DIV].neg[k] ? ELEM_W'(-mag[ELEM_W-1:0])
			                                : mag[ELEM_W-1:0];
			if (div_s[N_DIV].singular) begin
				elem_d[k] = '0;
			end
		end
		res_d.inv00    = elem_d[0];
		res_d.inv01    = elem_d[1];
		res_d.inv02    = elem_d[2];
		res_d.inv10    = elem_d[3];
		res_d.inv11    = elem_d[4];
		res_d.inv12    = elem_d[5];
		res_d.inv20    = elem_d[6];
		res_d.inv21    = elem_d[7];
		res_d.inv22    = elem_d[8];
		res_d.singular = div_s[N_DIV].singular;
		res_d.overflow = !div_s[N_DIV].singular && (sat_d != '0);
	end

	always_ff @(posedge clk) begin
		if (rdy[N_STG]) begin
			inv_s41 <= res_d;
		end
	end

	assign inv = inv_s41;

endmodule

/* test/inverse_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inverse_checker
// watches both channels of the 3x3 inverse, predicts each result and compares
// ----------------------------------------------------------------------------
module inverse_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          mat_valid,
	input  logic          mat_stall,
	input  mi3_pkg::in_t  mat,
	input  logic          inv_valid,
	input  logic          inv_stall,
	input  mi3_pkg::out_t inv,
	output int            fail_count,
	output int            pending
);
	import mi3_pkg::*;

	out_t expected_inv_q[$];

	// truncating signed quotient of cof * 2^32 by det, saturated
	function automatic logic [31:0] inv_elem(input logic signed [127:0] cofac,
			input logic signed [127:0] det, inout logic ovf);
		logic signed [127:0] num;
		logic [127:0] nmag, dmag, q;
		logic neg;
		logic [127:0] lim;
		begin
			neg  = cofac[127] ^ det[127];
			lim  = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
			num  = cofac <<< 32;
			nmag = num[127] ? -num : num;
			dmag = det[127] ? -det : det;
			q    = nmag / dmag;
			if (q > lim) begin
				ovf = 1'b1;
				q   = lim;
			end
			inv_elem = neg ? (32'd0 - q[31:0]) : q[31:0];
		end
	endfunction

	function automatic out_t predict_inverse(input in_t m);
		logic signed [127:0] a [9];
		logic signed [127:0] adj [9];
		logic signed [127:0] det;
		logic [31:0] e [9];
		logic ovf;
		out_t r;
		begin
			a[0] = m.a00; a[1] = m.a01; a[2] = m.a02;
			a[3] = m.a10; a[4] = m.a11; a[5] = m.a12;
			a[6] = m.a20; a[7] = m.a21; a[8] = m.a22;
			adj[0] =   a[4]*a[8] - a[7]*a[5];
			adj[1] = -(a[1]*a[8] - a[7]*a[2]);
			adj[2] =   a[1]*a[5] - a[4]*a[2];
			adj[3] = -(a[3]*a[8] - a[6]*a[5]);
			adj[4] =   a[0]*a[8] - a[6]*a[2];
			adj[5] = -(a[0]*a[5] - a[3]*a[2]);
			adj[6] =   a[3]*a[7] - a[6]*a[4];
			adj[7] = -(a[0]*a[7] - a[6]*a[1]);
			adj[8] =   a[0]*a[4] - a[3]*a[1];
			det = a[0]*adj[0] + a[1]*adj[3] + a[2]*adj[6];
			ovf = 1'b0;
			for (int k = 0; k < 9; k++)
				e[k] = (det == 0) ? 32'd0 : inv_elem(adj[k], det, ovf);
			r.inv00 = e[0]; r.inv01 = e[1]; r.inv02 = e[2];
			r.inv10 = e[3]; r.inv11 = e[4]; r.inv12 = e[5];
			r.inv20 = e[6]; r.inv21 = e[7]; r.inv22 = e[8];
			r.singular = (det == 0);
			r.overflow = (det == 0) ? 1'b0 : ovf;
			predict_inverse = r;
		end
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %h, actual %h", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_t e;
		if (!arst_n) begin
			fail_count = 0;
			pending = 0;
		end else begin
			if (mat_valid && !mat_stall)
				expected_inv_q.push_back(predict_inverse(mat));
			if (inv_valid && !inv_stall) begin
				if (expected_inv_q.size() == 0) begin
					$error("inverse item with no matrix waiting");
					fail_count++;
				end else begin
					e = expected_inv_q.pop_front();
					check_field("inv00", e.inv00, inv.inv00);
					check_field("inv01", e.inv01, inv.inv01);
					check_field("inv02", e.inv02, inv.inv02);
					check_field("inv10", e.inv10, inv.inv10);
					check_field("inv11", e.inv11, inv.inv11);
					check_field("inv12", e.inv12, inv.inv12);
					check_field("inv20", e.inv20, inv.inv20);
					check_field("inv21", e.inv21, inv.inv21);
					check_field("inv22", e.inv22, inv.inv22);
					check_field("singular", e.singular, inv.singular);
					check_field("overflow", e.overflow, inv.overflow);
				end
			end
			pending = expected_inv_q.size();
		end
	end
endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the 3x3 matrix inverse; checking lives in the checker
// ----------------------------------------------------------------------------
module tb_top;
	import mi3_pkg::*;

	localparam int N_RANDOM = 1030;
	localparam int DRAIN    = 100;   // settle time after the last result is checked

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  mat_valid = 1'b0;
	logic  mat_stall;
	in_t   mat = '0;
	logic  inv_valid;
	logic  inv_stall = 1'b0;
	out_t  inv;
	int    fail_count;
	int    pending;
	in_t   directed_q[$];

	always #6 clk = ~clk;

	matrix3x3_inverse dut (
		.clk(clk), .arst_n(arst_n),
		.mat_valid(mat_valid), .mat_stall(mat_stall), .mat(mat),
		.inv_valid(inv_valid), .inv_stall(inv_stall), .inv(inv)
	);

	inverse_checker chk (
		.clk(clk), .arst_n(arst_n),
		.mat_valid(mat_valid), .mat_stall(mat_stall), .mat(mat),
		.inv_valid(inv_valid), .inv_stall(inv_stall), .inv(inv),
		.fail_count(fail_count), .pending(pending)
	);

	// gap length: mostly none or short, now and then long
	function automatic int gap_len();
		int r;
		begin
			r = $urandom_range(0, 99);
			if (r < 55)      gap_len = 0;
			else if (r < 95) gap_len = $urandom_range(1, 3);
			else             gap_len = $urandom_range(10, 40);
		end
	endfunction

	function automatic logic [31:0] rand_elem();
		case ($urandom_range(0, 7))
			0:       rand_elem = 32'h8000_0000;
			1:       rand_elem = 32'h7FFF_FFFF;
			2:       rand_elem = 32'd0;
			3:       rand_elem = $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
			4:       rand_elem = $urandom;
			// small values keep the inverse in range
			default: rand_elem = $signed($urandom_range(0, 32'h6_0000)) - 32'sh3_0000;
		endcase
	endfunction

	function automatic in_t rand_matrix();
		in_t m;
		begin
			m = {rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
				rand_elem(), rand_elem(), rand_elem(), rand_elem()};
			// some singular ones: repeat a row or zero a column
			case ($urandom_range(0, 9))
				0: begin m.a20 = m.a00; m.a21 = m.a01; m.a22 = m.a02; end
				1: begin m.a01 = 0; m.a11 = 0; m.a21 = 0; end
				default: ;
			endcase
			rand_matrix = m;
		end
	endfunction

	task automatic send_matrix(input in_t m);
		int g;
		g = gap_len();
		if (g > 0) begin
			mat_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		mat <= m;
		mat_valid <= 1'b1;
		// hold until taken at a rising edge
		@(posedge clk);
		while (mat_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// receiver stalls at random, with calm stretches
	initial begin
		int g;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 3) == 0) begin
				g = gap_len();
				inv_stall <= (g > 0);
				repeat (g) @(negedge clk);
				inv_stall <= 1'b0;
			end
		end
	end

	initial begin
		in_t m;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// identity, zero, a scaled diagonal, all extremes, a tiny determinant, extreme diagonals and a permutation
		m = '0; m.a00 = 32'h0001_0000; m.a11 = 32'h0001_0000; m.a22 = 32'h0001_0000;
		directed_q.push_back(m);
		directed_q.push_back('0);
		m = '0; m.a00 = 32'h0002_0000; m.a11 = 32'hFFFC_0000; m.a22 = 32'h0000_8000;
		directed_q.push_back(m);
		directed_q.push_back({9{32'h8000_0000}});
		directed_q.push_back({9{32'h7FFF_FFFF}});
		directed_q.push_back({9{32'hFFFF_FFFF}});
		m = '0; m.a00 = 1; m.a11 = 1; m.a22 = 1;
		directed_q.push_back(m);
		m = '0; m.a00 = 32'h8000_0000; m.a11 = 32'h8000_0000; m.a22 = 32'h8000_0000;
		directed_q.push_back(m);
		m = '0; m.a00 = 32'h7FFF_FFFF; m.a11 = 32'h7FFF_FFFF; m.a22 = 32'h7FFF_FFFF;
		directed_q.push_back(m);
		m = '0; m.a02 = 32'h0001_0000; m.a10 = 32'h8000_0000; m.a21 = 32'h7FFF_FFFF;
		directed_q.push_back(m);
		// determinant large, quotients truncating to zero of either sign; then two dense matrices
		m = {32'h7FFF_FFFF, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd0,
			32'd0, 32'd0, 32'h8000_0000};
		directed_q.push_back(m);
		m = {32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678, 32'h7FFF_FFFF,
			32'h8000_0000, 32'hEDCB_A987, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F};
		directed_q.push_back(m);
		m = {32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000,
			32'h0005_0000, 32'h0006_0000, 32'h0007_0000, 32'h0008_0000, 32'h000A_0000};
		directed_q.push_back(m);
		foreach (directed_q[i]) send_matrix(directed_q[i]);

		repeat (N_RANDOM) send_matrix(rand_matrix());
		mat_valid <= 1'b0;

		wait (pending == 0);
		repeat (DRAIN) @(posedge clk);
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// generous cap: about 1050 items with long gaps and stalls
	initial begin
		#(12 * 400000);
		$display("Some tests failed");
		$finish;
	end
endmodule
